### hdl/ibp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibp_pkg
// Shared widths, status codes and controller/datapath signal groups for the
// indirect block path calculator.
// ----------------------------------------------------------------------------
package ibp_pkg;

  localparam int LB_W     = 64;
  localparam int PPB_W    = 15;
  localparam int OFF_W    = 14;
  localparam int LVL_W    = 3;
  localparam int CNT_W    = 4;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam int DIV_W    = LB_W + OFF_W;

  localparam int MUL_STEPS = PPB_W;
  localparam int DIV_STEPS = OFF_W;

  localparam logic [PPB_W-1:0] PPB_MIN   = PPB_W'(2);
  localparam logic [PPB_W-1:0] PPB_MAX   = PPB_W'(16384);
  localparam logic [PPB_W-1:0] PPB_RESET = PPB_W'(2048);

  localparam logic [LVL_W-1:0] MAX_PATH_LEVEL = LVL_W'(3);

  localparam logic [1:0] ST_DIRECT  = 2'd0;
  localparam logic [1:0] ST_PATH    = 2'd1;
  localparam logic [1:0] ST_TOO_BIG = 2'd2;

  localparam logic REG_PPB = 1'b0;

  typedef struct packed {
    logic             load;
    logic             init_search;
    logic             mul_start;
    logic             mul_step;
    logic             store_pow;
    logic             sub_rem;
    logic             meta_init;
    logic             div_start;
    logic             div_step;
    logic             meta_step;
    logic             out_direct;
    logic             out_too_big;
    logic             out_pair;
    logic             pair_first;
    logic             set_last;
    logic             last_val;
    logic [1:0]       k;
    logic [LVL_W-1:0] level;
    logic [LVL_W-1:0] tab_rd;
    logic [LVL_W-1:0] tab_wr;
  } ibp_cmd_t;

  typedef struct packed {
    logic direct;
    logic rem_lt;
    logic meta_eq;
  } ibp_sts_t;

endpackage

### hdl/ibp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibp_in_if
// Lookup channel: one signed logical block number per item.
// ----------------------------------------------------------------------------
interface ibp_in_if import ibp_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic signed [LB_W-1:0] logical_block;

  modport source (output valid, output logical_block, input ready);
  modport sink   (input valid, input logical_block, output ready);

endinterface

### hdl/ibp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibp_out_if
// Path channel: one (meta block, offset) pair per item.
// ----------------------------------------------------------------------------
interface ibp_out_if import ibp_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic [1:0]             level_index;
  logic signed [LB_W-1:0] meta_block;
  logic [OFF_W-1:0]       offset;
  logic [1:0]             status;
  logic                   last;

  modport source (output valid, output level_index, output meta_block, output offset,
                  output status, output last, input ready);
  modport sink   (input valid, input level_index, input meta_block, input offset,
                  input status, input last, output ready);

endinterface

### hdl/ibp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibp_datapath
// Magnitude, shift-add multiplier for the level sizes, restoring divider for
// the per-level offsets, meta block tracking and the result register.
// ----------------------------------------------------------------------------
module ibp_datapath import ibp_pkg::*; #(
  parameter int DIRECT_COUNT    = 12,
  parameter int INDIRECT_LEVELS = 3
) (
  input  logic              clk,
  input  ibp_cmd_t          cmd,
  output ibp_sts_t          sts,
  input  logic [LB_W-1:0]   logical_block,
  input  logic [PPB_W-1:0]  ppb,
  output logic [1:0]        level_index,
  output logic [LB_W-1:0]   meta_block,
  output logic [OFF_W-1:0]  offset,
  output logic [1:0]        status,
  output logic              last
);

  localparam int TAB_N = INDIRECT_LEVELS + 1;
  localparam int TAB_W = $clog2(TAB_N);

  logic [LB_W-1:0]  raw;
  logic [LB_W-1:0]  mag;
  logic [LB_W-1:0]  r;
  logic [LB_W-1:0]  r_old;
  logic [LB_W-1:0]  prod;
  logic [LB_W-1:0]  mcand;
  logic [PPB_W-1:0] mplier;
  logic [PPB_W-1:0] n;
  logic [LB_W-1:0]  pow_tab [TAB_N];
  logic [DIV_W-1:0] d;
  logic [OFF_W-1:0] q;
  logic [LB_W-1:0]  meta;

  logic [LB_W-1:0]  mag_in;
  logic [PPB_W-1:0] n_clamp;
  logic [LB_W-1:0]  pow_rd;
  logic             ge;

  assign mag_in  = logical_block[LB_W-1] ? (LB_W'(0) - logical_block) : logical_block;
  assign n_clamp = (ppb < PPB_MIN) ? PPB_MIN : ((ppb > PPB_MAX) ? PPB_MAX : ppb);
  assign pow_rd  = pow_tab[cmd.tab_rd[TAB_W-1:0]];
  assign ge      = {{OFF_W{1'b0}}, r} >= d;

  assign sts.direct  = mag < LB_W'(DIRECT_COUNT);
  assign sts.rem_lt  = r < prod;
  assign sts.meta_eq = meta == raw;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw <= logical_block;
      mag <= mag_in;
      n   <= n_clamp;
    end
    if (cmd.init_search) begin
      r <= mag - LB_W'(DIRECT_COUNT);
    end else if (cmd.sub_rem) begin
      r <= r - prod;
    end else if (cmd.div_step && ge) begin
      r <= r - d[LB_W-1:0];
    end
    if (cmd.div_start) begin
      r_old <= r;
      d     <= DIV_W'({{OFF_W{1'b0}}, pow_rd} << (OFF_W - 1));
      q     <= '0;
    end else if (cmd.div_step) begin
      d <= d >> 1;
      q <= {q[OFF_W-2:0], ge};
    end
    if (cmd.mul_start) begin
      prod   <= '0;
      mcand  <= pow_rd;
      mplier <= n;
    end else if (cmd.mul_step) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
    if (cmd.meta_init) begin
      meta <= LB_W'(0) - (mag - r + LB_W'(cmd.level));
    end else if (cmd.meta_step) begin
      meta <= meta + LB_W'(1) - (r_old - r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_search) begin
      pow_tab[0] <= LB_W'(1);
    end
    if (cmd.store_pow) begin
      pow_tab[cmd.tab_wr[TAB_W-1:0]] <= prod;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_direct) begin
      level_index <= 2'd0;
      meta_block  <= '0;
      offset      <= mag[OFF_W-1:0];
      status      <= ST_DIRECT;
      last        <= 1'b1;
    end else if (cmd.out_too_big) begin
      level_index <= 2'd0;
      meta_block  <= '0;
      offset      <= '0;
      status      <= ST_TOO_BIG;
      last        <= 1'b1;
    end else if (cmd.out_pair) begin
      level_index <= cmd.k;
      meta_block  <= meta;
      offset      <= cmd.pair_first ? OFF_W'(cmd.level) : q;
      status      <= ST_PATH;
      last        <= 1'b0;
    end else if (cmd.set_last) begin
      last <= cmd.last_val;
    end
  end

endmodule

### hdl/ibp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibp_ctrl
// Sequencer: direct check, level search, then one divide per path pair after the
// first, with the result handshake on the path channel.
// ----------------------------------------------------------------------------
module ibp_ctrl import ibp_pkg::*; #(
  parameter int INDIRECT_LEVELS = 3
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ibp_cmd_t cmd,
  input  ibp_sts_t sts
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLASS  = 4'd1;
  localparam logic [3:0] S_MSTART = 4'd2;
  localparam logic [3:0] S_MUL    = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_META   = 4'd5;
  localparam logic [3:0] S_PAIR0  = 4'd6;
  localparam logic [3:0] S_DSTART = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_PAIR   = 4'd9;
  localparam logic [3:0] S_MUPD   = 4'd10;
  localparam logic [3:0] S_LAST   = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [LVL_W-1:0] level, level_next;
  logic [1:0]       k, k_next;
  logic             fin, fin_next;

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_OUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      level <= '0;
      k     <= '0;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      level <= level_next;
      k     <= k_next;
      fin   <= fin_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    level_next   = level;
    k_next       = k;
    fin_next     = fin;
    cmd          = '0;
    cmd.k        = k;
    cmd.level    = level;
    cmd.tab_rd   = level;
    cmd.tab_wr   = level + LVL_W'(1);
    cmd.last_val = sts.meta_eq || ({1'b0, k} == level + LVL_W'(1));
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        if (sts.direct) begin
          cmd.out_direct = 1'b1;
          fin_next       = 1'b1;
          state_next     = S_OUT;
        end else begin
          cmd.init_search = 1'b1;
          level_next      = '0;
          state_next      = S_MSTART;
        end
      end
      S_MSTART: begin
        cmd.mul_start = 1'b1;
        cnt_next      = '0;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.store_pow = 1'b1;
        if (sts.rem_lt) begin
          if (level >= MAX_PATH_LEVEL) begin
            cmd.out_too_big = 1'b1;
            fin_next        = 1'b1;
            state_next      = S_OUT;
          end else begin
            state_next = S_META;
          end
        end else begin
          cmd.sub_rem = 1'b1;
          if (level == LVL_W'(INDIRECT_LEVELS - 1)) begin
            cmd.out_too_big = 1'b1;
            fin_next        = 1'b1;
            state_next      = S_OUT;
          end else begin
            level_next = level + LVL_W'(1);
            state_next = S_MSTART;
          end
        end
      end
      S_META: begin
        cmd.meta_init = 1'b1;
        k_next        = '0;
        state_next    = S_PAIR0;
      end
      S_PAIR0: begin
        cmd.out_pair   = 1'b1;
        cmd.pair_first = 1'b1;
        state_next     = S_LAST;
      end
      S_DSTART: begin
        cmd.tab_rd    = level + LVL_W'(1) - {1'b0, k};
        cmd.div_start = 1'b1;
        cnt_next      = '0;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_PAIR;
        end
      end
      S_PAIR: begin
        cmd.out_pair = 1'b1;
        state_next   = S_MUPD;
      end
      S_MUPD: begin
        cmd.meta_step = 1'b1;
        state_next    = S_LAST;
      end
      S_LAST: begin
        cmd.set_last = 1'b1;
        fin_next     = cmd.last_val;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (fin) begin
            fin_next   = 1'b0;
            state_next = S_IDLE;
          end else begin
            k_next     = k + 2'd1;
            state_next = S_DSTART;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CLASS))
    else $error("accepted item did not start classification");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(fin) && $stable(k)))
    else $error("result dropped while stalled");

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (cnt < CNT_W'(MUL_STEPS)))
    else $error("multiplier step count overrun");

  a_div_pair: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ((k != 2'd0) && ({1'b0, k} <= level + LVL_W'(1))))
    else $error("divide for a pair beyond the path length");

  a_check_level: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (level < LVL_W'(INDIRECT_LEVELS)))
    else $error("level search ran past the last level");

endmodule

### hdl/indirect_block_path_calc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indirect_block_path_calc_core
// Maps a signed logical file block number to its path of (meta block,
// offset) pairs through the single, double or triple indirect tree.
// ----------------------------------------------------------------------------
// Usage:
//   lookup : one signed logical block per item; negative names a meta block.
//   path   : one item per path pair, last set on the final pair of a lookup.
//            A direct block or a too-big number gives a single item.
//   APB    : pointers_per_block at byte address 0 (reset 2048), to be written by the user
//            only while no lookup is in flight (the block does not enforce this); pready is always high.
//   Order of steps (one lookup at a time, lookup.ready high only when idle):
//   direct block : item valid after the S_CLASS state
//   level search : S_MSTART, S_MUL and S_CHECK per level tried (shift-add multiplier
//                  forming pointers_per_block to the power of the level plus one)
//   first pair   : valid after the S_META, S_PAIR0 and S_LAST states that follow the search
//   later pairs  : S_DSTART, the restoring divider in S_DIV, then S_PAIR, S_MUPD, S_LAST
//   the next lookup can be taken in the cycle after the final item is accepted.
// Reset clears the sequencer; pointers_per_block returns to 2048.
// A stalled path channel holds the item and the sequencer waits on it.
// ----------------------------------------------------------------------------
module indirect_block_path_calc_core import ibp_pkg::*; #(
  parameter int DIRECT_COUNT    = 12,
  parameter int INDIRECT_LEVELS = 3
) (
  input  logic              clk,
  input  logic              rst,
  ibp_in_if.sink            lookup,
  ibp_out_if.source         path,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [PPB_W-1:0] pointers_per_block;
  ibp_cmd_t         cmd;
  ibp_sts_t         sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PPB) ? DATA_W'(pointers_per_block) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pointers_per_block <= PPB_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_PPB)) begin
      pointers_per_block <= pwdata[PPB_W-1:0];
    end
  end

  ibp_ctrl #(
    .INDIRECT_LEVELS (INDIRECT_LEVELS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lookup.valid),
    .in_ready  (lookup.ready),
    .out_valid (path.valid),
    .out_ready (path.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ibp_datapath #(
    .DIRECT_COUNT    (DIRECT_COUNT),
    .INDIRECT_LEVELS (INDIRECT_LEVELS)
  ) u_datapath (
    .clk           (clk),
    .cmd           (cmd),
    .sts           (sts),
    .logical_block (lookup.logical_block),
    .ppb           (pointers_per_block),
    .level_index   (path.level_index),
    .meta_block    (path.meta_block),
    .offset        (path.offset),
    .status        (path.status),
    .last          (path.last)
  );

endmodule
